>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous reset disable
`define CDAS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication built on the clocked form
`define CDAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	`CDAS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

>>> src/cdas_pkg.sv
// types, constants and calendar helpers for the date add/subtract block
`default_nettype none
package cdas_pkg;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int DOY_W    = 9;
	localparam int KQ_W     = 11;  // signed day count before year normalization
	localparam int CENT_Q_W = 8;   // year / 100
	localparam int CENT_R_W = 7;   // year % 100

	localparam logic [DOY_W-1:0]   DAYS_YEAR = 9'd365;
	localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
	localparam logic [MONTH_W-1:0] MON_JAN   = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB   = 4'd2;
	localparam logic [MONTH_W-1:0] MON_DEC   = 4'd12;

	// year / 100 as (year * RECIP_100) >> RECIP_SHIFT, exact for 14-bit years
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;
	localparam logic [CENT_R_W-1:0] CENTURY = 7'd100;

	typedef enum logic {
		REQ_ADD = 1'b0,
		REQ_SUB = 1'b1
	} req_t;

	// days in the months before month m (1..12), february grows in leap years
	function automatic logic [DOY_W-1:0] cum_before(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DOY_W-1:0] base;
		begin
			case (m)
				4'd1:    base = 9'd0;
				4'd2:    base = 9'd31;
				4'd3:    base = 9'd59;
				4'd4:    base = 9'd90;
				4'd5:    base = 9'd120;
				4'd6:    base = 9'd151;
				4'd7:    base = 9'd181;
				4'd8:    base = 9'd212;
				4'd9:    base = 9'd243;
				4'd10:   base = 9'd273;
				4'd11:   base = 9'd304;
				4'd12:   base = 9'd334;
				default: base = 9'd0;
			endcase
			cum_before = base + ((leap && m > MON_FEB) ? 9'd1 : 9'd0);
		end
	endfunction

endpackage
`default_nettype wire

>>> src/calendar_date_add_subtract.sv
// top level of the gregorian date add/subtract pipeline
`default_nettype none
// Adds or subtracts 0..511 days to a Gregorian date and returns the new date,
// together with the day of year and leap flag of the input date. The block is
// a six-stage pipeline with no state between transactions: it takes one
// transaction per clock when the output side does not stall. Stage 1 finds
// the century of the year with a reciprocal multiply and looks up the days
// before the (clamped) month; stage 2 derives the century remainder, then the
// leap flags of the input year and its two neighbors on each side; stage 3
// forms the day of year and the signed day count; stage 4 carries or borrows
// up to two whole years; stage 5 finds the result month; stage 6 is the output
// register, which subtracts the month start and applies the range check. Each
// stage holds its transaction while the next one is full and stalled, and
// fills a bubble even when the output stalls, so nothing is dropped or
// repeated. A result year outside 1..9999 raises the range error flag in
// m_axis_tuser and the date fields then echo the input day, month and year as
// received. Month 0 is treated as january and months above 12 as december for
// the arithmetic. There is no configuration.
module calendar_date_add_subtract
	import cdas_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // day[4:0], month[8:5], year[22:9], offset[31:23]
	input  wire logic        s_axis_tuser,   // req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // res_day[4:0], res_month[8:5], res_year[22:9],
	                                         // in_day_of_year[31:23], in_is_leap[32], zeros
	output logic             m_axis_tuser    // range_error
);

	// stage enables: a stage loads when it is empty or its successor moves
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign en_s6 = !v_s6 || m_axis_tready;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_axis_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// ---------------- stage 1: unpack, century split, month table ----------------
	logic [DAY_W-1:0]   in_day;
	logic [MONTH_W-1:0] in_month, month_c;
	logic [YEAR_W-1:0]  in_year;
	logic [DOY_W-1:0]   in_off;
	logic [26:0]        recip_prod;

	assign in_day   = s_axis_tdata[4:0];
	assign in_month = s_axis_tdata[8:5];
	assign in_year  = s_axis_tdata[22:9];
	assign in_off   = s_axis_tdata[31:23];

	always_comb begin
		if (in_month < MON_JAN)
			month_c = MON_JAN;
		else if (in_month > MON_DEC)
			month_c = MON_DEC;
		else
			month_c = in_month;
	end

	assign recip_prod = 27'(in_year) * 27'(RECIP_100);

	logic               req_s1;
	logic [DAY_W-1:0]   day_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [YEAR_W-1:0]  year_s1;
	logic [DOY_W-1:0]   off_s1;
	logic [CENT_Q_W-1:0] cq_s1;
	logic [DOY_W-1:0]   cum_s1;
	logic               feb_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			req_s1   <= s_axis_tuser;
			day_s1   <= in_day;
			month_s1 <= in_month;
			year_s1  <= in_year;
			off_s1   <= in_off;
			cq_s1    <= recip_prod[RECIP_SHIFT +: CENT_Q_W];
			cum_s1   <= cum_before(month_c, 1'b0);
			feb_s1   <= month_c > MON_FEB;
		end
	end

	// ---------------- stage 2: leap flags for year-2 .. year+2 ----------------
	logic [14:0]         cent_prod;
	logic [CENT_R_W-1:0] cr;
	logic [4:0]          leap_n;   // bit k is the leap flag of year + k - 2
	logic [CENT_Q_W-1:0] cq_inc;

	assign cent_prod = 15'(cq_s1) * 15'(CENTURY);
	assign cr        = CENT_R_W'(15'(year_s1) - cent_prod);
	assign cq_inc    = cq_s1 + 8'd1;

	always_comb begin
		logic signed [7:0] s;
		logic [1:0]        lo;
		logic              div100, div400;
		for (int k = 0; k < 5; k++) begin
			s  = $signed({1'b0, cr}) + 8'(k - 2);
			lo = year_s1[1:0] + 2'(k - 2);
			// the remainder reaching 0 or 100 marks a whole century
			div100 = (s == 8'sd0) || (s == 8'sd100);
			div400 = (s == 8'sd0) ? (cq_s1[1:0] == 2'd0) : (cq_inc[1:0] == 2'd0);
			leap_n[k] = (lo == 2'd0) && (!div100 || div400);
		end
	end

	logic               req_s2;
	logic [DAY_W-1:0]   day_s2;
	logic [MONTH_W-1:0] month_s2;
	logic [YEAR_W-1:0]  year_s2;
	logic [DOY_W-1:0]   off_s2;
	logic [DOY_W-1:0]   cum_s2;
	logic               feb_s2;
	logic [4:0]         leap_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			req_s2   <= req_s1;
			day_s2   <= day_s1;
			month_s2 <= month_s1;
			year_s2  <= year_s1;
			off_s2   <= off_s1;
			cum_s2   <= cum_s1;
			feb_s2   <= feb_s1;
			leap_s2  <= leap_n;
		end
	end

	// ---------------- stage 3: day of year and signed day count ----------------
	logic [DOY_W-1:0]       doy;
	logic signed [KQ_W-1:0] kq;

	assign doy = 9'(day_s2) + cum_s2 + ((leap_s2[2] && feb_s2) ? 9'd1 : 9'd0);
	assign kq  = (req_t'(req_s2) == REQ_SUB) ?
		$signed({2'b00, doy}) - $signed({2'b00, off_s2}) :
		$signed({2'b00, doy}) + $signed({2'b00, off_s2});

	logic [DAY_W-1:0]       day_s3;
	logic [MONTH_W-1:0]     month_s3;
	logic [YEAR_W-1:0]      year_s3;
	logic [DOY_W-1:0]       doy_s3;
	logic signed [KQ_W-1:0] kq_s3;
	logic [4:0]             leap_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			day_s3   <= day_s2;
			month_s3 <= month_s2;
			year_s3  <= year_s2;
			doy_s3   <= doy;
			kq_s3    <= kq;
			leap_s3  <= leap_s2;
		end
	end

	// ---------------- stage 4: carry or borrow whole years ----------------
	logic signed [KQ_W-1:0] len_m2, len_m1, len_0, len_p1;
	logic signed [KQ_W-1:0] kc1, kc2, kb1, kb2;
	logic                   c1, c2, b1, b2;
	logic signed [KQ_W-1:0] kq_n;
	logic signed [2:0]      yoff;
	logic                   rl;
	logic [15:0]            y_n;
	logic                   err_n;

	assign len_m2 = $signed({2'b00, DAYS_YEAR}) + (leap_s3[0] ? 11'sd1 : 11'sd0);
	assign len_m1 = $signed({2'b00, DAYS_YEAR}) + (leap_s3[1] ? 11'sd1 : 11'sd0);
	assign len_0  = $signed({2'b00, DAYS_YEAR}) + (leap_s3[2] ? 11'sd1 : 11'sd0);
	assign len_p1 = $signed({2'b00, DAYS_YEAR}) + (leap_s3[3] ? 11'sd1 : 11'sd0);

	assign c1  = kq_s3 > len_0;
	assign kc1 = kq_s3 - len_0;
	assign c2  = c1 && (kc1 > len_p1);
	assign kc2 = kc1 - len_p1;
	assign b1  = kq_s3 < 11'sd1;
	assign kb1 = kq_s3 + len_m1;
	assign b2  = b1 && (kb1 < 11'sd1);
	assign kb2 = kb1 + len_m2;

	always_comb begin
		if (c2) begin
			kq_n = kc2; yoff = 3'sd2;  rl = leap_s3[4];
		end else if (c1) begin
			kq_n = kc1; yoff = 3'sd1;  rl = leap_s3[3];
		end else if (b2) begin
			kq_n = kb2; yoff = -3'sd2; rl = leap_s3[0];
		end else if (b1) begin
			kq_n = kb1; yoff = -3'sd1; rl = leap_s3[1];
		end else begin
			kq_n = kq_s3; yoff = 3'sd0; rl = leap_s3[2];
		end
	end

	// result year as a 16-bit two's complement value, negative below year 0
	assign y_n   = {2'b00, year_s3} + {{13{yoff[2]}}, yoff};
	assign err_n = y_n[15] || (y_n == 16'd0) || (y_n > {2'b00, YEAR_MAX});

	logic [DAY_W-1:0]   day_s4;
	logic [MONTH_W-1:0] month_s4;
	logic [YEAR_W-1:0]  year_s4;
	logic [DOY_W-1:0]   doy_s4;
	logic               inleap_s4;
	logic [DOY_W-1:0]   rem_s4;
	logic               rl_s4;
	logic [YEAR_W-1:0]  ry_s4;
	logic               err_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			day_s4    <= day_s3;
			month_s4  <= month_s3;
			year_s4   <= year_s3;
			doy_s4    <= doy_s3;
			inleap_s4 <= leap_s3[2];
			rem_s4    <= kq_n[DOY_W-1:0];
			rl_s4     <= rl;
			ry_s4     <= y_n[YEAR_W-1:0];
			err_s4    <= err_n;
		end
	end

	// ---------------- stage 5: result month ----------------
	logic [MONTH_W-1:0] rmon;

	// the month ends form a rising threshold list, the last one passed wins
	always_comb begin
		rmon = MON_JAN;
		for (int k = 1; k < 12; k++) begin
			if (rem_s4 > cum_before(MONTH_W'(k + 1), rl_s4))
				rmon = MONTH_W'(k + 1);
		end
	end

	logic [DAY_W-1:0]   day_s5;
	logic [MONTH_W-1:0] month_s5;
	logic [YEAR_W-1:0]  year_s5;
	logic [DOY_W-1:0]   doy_s5;
	logic               inleap_s5;
	logic [DOY_W-1:0]   rem_s5;
	logic [DOY_W-1:0]   mstart_s5;
	logic [MONTH_W-1:0] rmon_s5;
	logic [YEAR_W-1:0]  ry_s5;
	logic               err_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			day_s5    <= day_s4;
			month_s5  <= month_s4;
			year_s5   <= year_s4;
			doy_s5    <= doy_s4;
			inleap_s5 <= inleap_s4;
			rem_s5    <= rem_s4;
			mstart_s5 <= cum_before(rmon, rl_s4);
			rmon_s5   <= rmon;
			ry_s5     <= ry_s4;
			err_s5    <= err_s4;
		end
	end

	// ---------------- stage 6: output register ----------------
	logic [DOY_W-1:0]   rday_full;
	logic [DAY_W-1:0]   rday_s6;
	logic [MONTH_W-1:0] rmon_s6;
	logic [YEAR_W-1:0]  ryear_s6;
	logic [DOY_W-1:0]   doy_s6;
	logic               inleap_s6;
	logic               err_s6;

	assign rday_full = rem_s5 - mstart_s5;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			// out of range: echo the input date exactly as received
			rday_s6   <= err_s5 ? day_s5   : rday_full[DAY_W-1:0];
			rmon_s6   <= err_s5 ? month_s5 : rmon_s5;
			ryear_s6  <= err_s5 ? year_s5  : ry_s5;
			doy_s6    <= doy_s5;
			inleap_s6 <= inleap_s5;
			err_s6    <= err_s5;
		end
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = {7'd0, inleap_s6, doy_s6, ryear_s6, rmon_s6, rday_s6};
	assign m_axis_tuser  = err_s6;

endmodule
`default_nettype wire

>>> src/cdas_checker.sv
// port-level checker for the date add/subtract block, with its bind
`default_nettype none
`include "assert_macros.svh"
module cdas_checker
	import cdas_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);

	logic out_ok;
	assign out_ok = m_axis_tvalid && !m_axis_tuser;

	// a result is held until taken
	`CDAS_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
	// and its payload does not move meanwhile
	`CDAS_ASSERT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
	// a result without range error carries a year in 1..9999
	`CDAS_ASSERT_IMP(a_year_range, clk, arst_n, out_ok, (m_axis_tdata[22:9] != 14'd0) && (m_axis_tdata[22:9] <= YEAR_MAX), "result year out of range without error")
	// a result without range error carries a real month and day
	`CDAS_ASSERT_IMP(a_date_range, clk, arst_n, out_ok, (m_axis_tdata[8:5] >= MON_JAN) && (m_axis_tdata[8:5] <= MON_DEC) && (m_axis_tdata[4:0] != 5'd0), "result month or day invalid")
	// an empty pipeline never refuses input: a stalled output alone blocks
	`CDAS_ASSERT_IMP(a_ready, clk, arst_n, !m_axis_tvalid, s_axis_tready || $past(s_axis_tvalid), "input refused with output empty")

endmodule

bind calendar_date_add_subtract cdas_checker u_cdas_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
